>>> hw/rtl/lbc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the LRU block cache
// Request and result payloads, operation and status codes, register indexes,
// and the search token that travels down the row of entry cells.
// ---------------------------------------------------------------------------
package lbc_pkg;

  localparam int ENTRIES_DEF     = 256;
  localparam int BLOCK_BYTES_DEF = 256;

  localparam int IDX_W  = 12;
  localparam int KEY_W  = 14;
  localparam int TICK_W = 32;
  localparam int WORD_W = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'd1;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_DISABLED = 3'd2;
  localparam logic [2:0] ST_BAD_KEY  = 3'd3;
  localparam logic [2:0] ST_PRESENT  = 3'd4;

  localparam logic [4:0] DISK_LIMIT  = 5'd16;
  localparam logic [8:0] BLOCK_LIMIT = 9'd256;

  typedef struct packed {
    logic [1:0]        operation;
    logic [4:0]        disk_number;
    logic [8:0]        block_number;
    logic [WORD_W-1:0] data_word;
    logic [4:0]        beat_index;
    logic              last_beat;
  } in_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] read_word;
    logic [4:0]        read_beat;
    logic              last_result;
    logic [31:0]       query_total;
    logic [31:0]       hit_total;
  } out_req_t;

  typedef struct packed {
    logic              live;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic [TICK_W-1:0] best_age;
    logic [IDX_W-1:0]  best_idx;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              set_key;
    logic [KEY_W-1:0]  key;
    logic [TICK_W-1:0] stamp;
  } wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/lbc_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lbc_cell: one cache entry cell
// Holds the valid mark, key and stamp of one entry, folds its own state into
// the passing search token and hands the token to the next cell.
// ---------------------------------------------------------------------------
module lbc_cell import lbc_pkg::*; #(
  parameter int IDX = 0,
  parameter int NW  = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hold,
  input  logic             clear,
  input  logic [KEY_W-1:0] key_i,
  input  logic [NW-1:0]    n_i,
  input  logic [TICK_W-1:0] tick_i,
  input  wr_t              wr_i,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  output logic             match_o
);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [TICK_W-1:0] stamp_r;
  tok_t              tok_r, tok_nxt;
  logic              act, sel, is_free, older;
  logic [TICK_W-1:0] age;

  assign act     = NW'(IDX) < n_i;
  assign sel     = wr_i.en && (wr_i.idx == IDX_W'(IDX));
  assign match_o = act && valid_r && (key_r == key_i);
  assign is_free = act && !valid_r;
  assign age     = tick_i - stamp_r;
  assign older   = (IDX == 0) || (age > tok_i.best_age);

  always_comb begin
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (sel && wr_i.set_key) begin
      valid_nxt = 1'b1;
    end
  end

  always_comb begin
    tok_nxt = tok_i;
    if (match_o && !tok_i.hit) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = IDX_W'(IDX);
    end
    if (is_free && !tok_i.free) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = IDX_W'(IDX);
    end
    if (act && older) begin
      tok_nxt.best_age = age;
      tok_nxt.best_idx = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= wr_i.stamp;
      if (wr_i.set_key) begin
        key_r <= wr_i.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.live <= 1'b0;
    end else if (!hold) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

>>> hw/rtl/lru_block_cache.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lru_block_cache: fully associative block cache with LRU replacement
// A row of entry cells passes a search token one cell per cycle unless a copy
// holds it; a sequencer copies staged blocks to the block store, streams hit blocks out.
// ---------------------------------------------------------------------------
//   channel   ports                          carries
//   request   in_valid / in_ready / in_req   operation, key, one data beat
//   result    out_valid / out_ready / out_req status, block beat, counters
//   config    cfg_we / cfg_index / cfg_data  enable, entries in use
//
// Data beats, ignored codes and rejected requests are handled in the idle
// state without a search. A search walks the token through all ENTRIES
// cells. An update copies the staged block into each matching entry as the
// token reaches it, an insert then copies it into the victim entry, and a
// hit streams its beats, pausing while the result is stalled, through the
// one read port of the block store. Reset is synchronous and needs no
// clearing pass. A stalled result holds the output register and blocks new requests.
// ---------------------------------------------------------------------------
module lru_block_cache import lbc_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_req_t              out_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BEATS = (BLOCK_BYTES + 7) / 8;
  localparam int OB    = (BEATS < 32) ? BEATS : 32;
  localparam int IW    = $clog2(ENTRIES);
  localparam int NW    = $clog2(ENTRIES + 1);
  localparam int SW    = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int CW    = $clog2(BEATS + 1);
  localparam int RW    = $clog2(OB + 1);
  localparam int AW    = (ENTRIES * BEATS > 1) ? $clog2(ENTRIES * BEATS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]        state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              en_r, en_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [31:0]       qcnt_r, qcnt_nxt, hcnt_r, hcnt_nxt;
  logic [NW-1:0]     pos_r, pos_nxt;
  logic              skip_r, skip_nxt, any_r, any_nxt, head_r, head_nxt;
  logic [AW-1:0]     base_r, base_nxt, cp_wa_r, cp_wa_nxt;
  logic [CW-1:0]     cp_cnt_r, cp_cnt_nxt;
  logic              cp_pend_r, cp_pend_nxt;
  logic [2:0]        rsp_r, rsp_nxt;
  logic [RW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [4:0]        rd_beat_r, rd_beat_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_req_t          out_r, out_nxt;

  logic [WORD_W-1:0] stg_mem [BEATS];
  logic [WORD_W-1:0] blk_mem [ENTRIES * BEATS];
  logic [WORD_W-1:0] stg_q_r, blk_q_r;

  logic              stg_we, stg_re, blk_re;
  logic [SW-1:0]     stg_wa, stg_ra;
  logic [AW-1:0]     blk_ra;
  logic              hold, clear_all, out_free, accept, upd_req, bad_key;
  wr_t               wr;
  tok_t              tok [ENTRIES + 1];
  tok_t              tok_last;
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES:0]  live_vec;
  logic [IDX_W-1:0]  victim;
  logic [KEY_W-1:0]  in_key;

  function automatic out_req_t rsp(input logic [2:0] st, input logic [31:0] q,
                                   input logic [31:0] h);
    out_req_t r;
    r             = '0;
    r.status      = st;
    r.last_result = 1'b1;
    r.query_total = q;
    r.hit_total   = h;
    return r;
  endfunction

  assign tok[0]   = '{live: head_r, hit: 1'b0, hit_idx: '0, free: 1'b0, free_idx: '0,
                      best_age: '0, best_idx: '0};
  assign tok_last = tok[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lbc_cell #(.IDX(g), .NW(NW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .hold    (hold),
      .clear   (clear_all),
      .key_i   (key_r),
      .n_i     (n_r),
      .tick_i  (tick_r),
      .wr_i    (wr),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .match_o (match_vec[g])
    );
  end

  always_comb begin
    for (int i = 0; i <= ENTRIES; i++) begin
      live_vec[i] = tok[i].live;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign in_key    = {in_req.disk_number, in_req.block_number};
  assign bad_key   = (in_req.disk_number > DISK_LIMIT) || (in_req.block_number > BLOCK_LIMIT);
  assign upd_req   = (state_r == S_SCAN) && (op_r == OP_UPDATE) && !skip_r &&
                     (pos_r < NW'(ENTRIES)) && match_vec[pos_r[IW-1:0]];
  assign victim    = tok_last.free ? tok_last.free_idx : tok_last.best_idx;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    en_nxt      = en_r;
    n_nxt       = n_r;
    tick_nxt    = tick_r;
    qcnt_nxt    = qcnt_r;
    hcnt_nxt    = hcnt_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    any_nxt     = any_r;
    head_nxt    = head_r;
    base_nxt    = base_r;
    cp_wa_nxt   = cp_wa_r;
    cp_cnt_nxt  = cp_cnt_r;
    cp_pend_nxt = 1'b0;
    rsp_nxt     = rsp_r;
    rd_cnt_nxt  = rd_cnt_r;
    rd_pend_nxt = 1'b0;
    rd_beat_nxt = rd_beat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt     = out_r;
    hold        = 1'b0;
    clear_all   = 1'b0;
    wr          = '0;
    stg_we      = 1'b0;
    stg_wa      = SW'(in_req.beat_index);
    stg_re      = 1'b0;
    stg_ra      = SW'(cp_cnt_r);
    blk_re      = 1'b0;
    blk_ra      = base_r + AW'(rd_cnt_r);

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: begin
          en_nxt    = cfg_data[0];
          clear_all = !cfg_data[0];
        end
        CFG_ENTRIES: begin
          if (cfg_data < 9'd2) begin
            n_nxt = NW'(2);
          end else if (32'(cfg_data) > ENTRIES) begin
            n_nxt = NW'(ENTRIES);
          end else begin
            n_nxt = NW'(cfg_data);
          end
        end
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_req.operation;
          key_nxt  = in_key;
          pos_nxt  = '0;
          skip_nxt = 1'b0;
          any_nxt  = 1'b0;
          unique case (in_req.operation) inside
            OP_LOOKUP: begin
              if (!en_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = rsp(ST_DISABLED, qcnt_r, hcnt_r);
              end else begin
                qcnt_nxt  = qcnt_r + 32'd1;
                head_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            OP_INSERT, OP_UPDATE: begin
              stg_we = 32'(in_req.beat_index) < BEATS;
              if (in_req.last_beat) begin
                if ((in_req.operation == OP_INSERT) && bad_key) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = rsp(ST_BAD_KEY, qcnt_r, hcnt_r);
                end else if (!en_r) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = rsp(ST_DISABLED, qcnt_r, hcnt_r);
                end else begin
                  head_nxt  = 1'b1;
                  state_nxt = S_SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (upd_req) begin
          hold       = 1'b1;
          wr.en      = 1'b1;
          wr.idx     = IDX_W'(pos_r);
          wr.stamp   = tick_r + 32'd1;
          tick_nxt   = tick_r + 32'd1;
          any_nxt    = 1'b1;
          skip_nxt   = 1'b1;
          base_nxt   = AW'(pos_r) * AW'(BEATS);
          cp_cnt_nxt = '0;
          ret_nxt    = S_SCAN;
          state_nxt  = S_COPY;
        end else begin
          head_nxt = 1'b0;
          skip_nxt = 1'b0;
          if (pos_r == NW'(ENTRIES)) begin
            unique case (op_r)
              OP_LOOKUP: begin
                if (tok_last.hit) begin
                  hcnt_nxt   = hcnt_r + 32'd1;
                  tick_nxt   = tick_r + 32'd1;
                  wr.en      = 1'b1;
                  wr.idx     = tok_last.hit_idx;
                  wr.stamp   = tick_r + 32'd1;
                  base_nxt   = AW'(tok_last.hit_idx) * AW'(BEATS);
                  rd_cnt_nxt = '0;
                  state_nxt  = S_READ;
                end else begin
                  rsp_nxt   = ST_MISS;
                  state_nxt = S_RESP;
                end
              end
              OP_INSERT: begin
                if (tok_last.hit) begin
                  rsp_nxt   = ST_PRESENT;
                  state_nxt = S_RESP;
                end else begin
                  wr.en      = 1'b1;
                  wr.idx     = victim;
                  wr.set_key = 1'b1;
                  wr.key     = key_r;
                  wr.stamp   = tick_r + 32'd1;
                  tick_nxt   = tick_r + 32'd1;
                  base_nxt   = AW'(victim) * AW'(BEATS);
                  cp_cnt_nxt = '0;
                  rsp_nxt    = ST_OK;
                  ret_nxt    = S_RESP;
                  state_nxt  = S_COPY;
                end
              end
              default: begin
                rsp_nxt   = any_r ? ST_OK : ST_MISS;
                state_nxt = S_RESP;
              end
            endcase
          end else begin
            pos_nxt = pos_r + NW'(1);
          end
        end
      end
      S_COPY: begin
        hold = 1'b1;
        if (cp_cnt_r < CW'(BEATS)) begin
          stg_re      = 1'b1;
          cp_pend_nxt = 1'b1;
          cp_wa_nxt   = base_r + AW'(cp_cnt_r);
          cp_cnt_nxt  = cp_cnt_r + CW'(1);
        end else if (!cp_pend_r) begin
          state_nxt = ret_r;
        end
      end
      S_READ: begin
        if (rd_pend_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_OK, read_word: blk_q_r, read_beat: rd_beat_r,
                            last_result: rd_beat_r == 5'(OB - 1),
                            query_total: qcnt_r, hit_total: hcnt_r};
        end
        if ((rd_cnt_r < RW'(OB)) && !rd_pend_r && out_free) begin
          blk_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_beat_nxt = 5'(rd_cnt_r);
          rd_cnt_nxt  = rd_cnt_r + RW'(1);
        end else if ((rd_cnt_r == RW'(OB)) && !rd_pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = rsp(rsp_r, qcnt_r, hcnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_wa] <= in_req.data_word;
    end
    if (stg_re) begin
      stg_q_r <= stg_mem[stg_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cp_pend_r) begin
      blk_mem[cp_wa_r] <= stg_q_r;
    end
    if (blk_re) begin
      blk_q_r <= blk_mem[blk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b0;
      n_r         <= NW'(2);
      tick_r      <= '0;
      qcnt_r      <= '0;
      hcnt_r      <= '0;
      head_r      <= 1'b0;
      skip_r      <= 1'b0;
      cp_pend_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      n_r         <= n_nxt;
      tick_r      <= tick_nxt;
      qcnt_r      <= qcnt_nxt;
      hcnt_r      <= hcnt_nxt;
      head_r      <= head_nxt;
      skip_r      <= skip_nxt;
      cp_pend_r   <= cp_pend_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    pos_r     <= pos_nxt;
    any_r     <= any_nxt;
    base_r    <= base_nxt;
    cp_wa_r   <= cp_wa_nxt;
    cp_cnt_r  <= cp_cnt_nxt;
    rsp_r     <= rsp_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    rd_beat_r <= rd_beat_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(live_vec) <= 1)
    else $error("more than one search token in the cell row");

  a_beat_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (!out_valid_r || out_ready))
    else $error("block beat arrived while the result register was busy");

  a_copy_only: assert property (@(posedge clk) disable iff (!rst_n)
    cp_pend_r |-> (state_r == S_COPY))
    else $error("block store written outside a copy");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (tick_r == $past(tick_r)) || (tick_r == $past(tick_r) + 32'd1))
    else $error("tick counter moved by more than one");

endmodule
`default_nettype wire

>>> tb/lbc_scoreboard.sv
// ---------------------------------------------------------------------------
// lbc_scoreboard: result checker of the LRU block cache
// Watches the request, result and register ports, keeps its own image of the
// cache, queues the results that each accepted request must produce and
// compares every returned result with the oldest one waiting.
// ---------------------------------------------------------------------------
module lbc_scoreboard import lbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_req_t               in_req,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_req_t              out_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int NENT  = 256;
  localparam int BEATS = 32;

  bit              enabled;
  int              use_count;
  bit              line_valid [NENT];
  logic [13:0]     line_key   [NENT];
  logic [31:0]     line_stamp [NENT];
  logic [63:0]     line_data  [NENT][BEATS];
  logic [63:0]     staging    [BEATS];
  logic [31:0]     tick;
  logic [31:0]     query_count;
  logic [31:0]     hit_count;
  out_req_t        expected_results [$];

  assign pending = expected_results.size();

  function automatic int active_entries();
    if (use_count < 2) return 2;
    if (use_count > NENT) return NENT;
    return use_count;
  endfunction

  function automatic int find_line(int n, logic [13:0] k);
    for (int i = 0; i < n; i++)
      if (line_valid[i] && line_key[i] == k) return i;
    return -1;
  endfunction

  task automatic queue_result(logic [2:0] st, logic [63:0] w, logic [4:0] b, logic l);
    out_req_t res;
    res.status      = st;
    res.read_word   = w;
    res.read_beat   = b;
    res.last_result = l;
    res.query_total = query_count;
    res.hit_total   = hit_count;
    expected_results.push_back(res);
  endtask

  task automatic fill_line(int e);
    for (int j = 0; j < BEATS; j++) line_data[e][j] = staging[j];
    tick = tick + 1;
    line_stamp[e] = tick;
  endtask

  task automatic predict_request(in_req_t r);
    logic [13:0] k;
    int          n;
    int          e;
    int          victim;
    logic [31:0] best;
    logic [31:0] age;
    bit          any;
    k = {r.disk_number, r.block_number};
    n = active_entries();
    if (r.operation == OP_LOOKUP) begin
      if (!enabled) begin
        queue_result(ST_DISABLED, '0, '0, 1'b1);
        return;
      end
      query_count = query_count + 1;
      e = find_line(n, k);
      if (e < 0) begin
        queue_result(ST_MISS, '0, '0, 1'b1);
        return;
      end
      hit_count = hit_count + 1;
      tick = tick + 1;
      line_stamp[e] = tick;
      for (int i = 0; i < BEATS; i++)
        queue_result(ST_OK, line_data[e][i], i[4:0], i == BEATS - 1);
    end else if (r.operation == OP_INSERT || r.operation == OP_UPDATE) begin
      staging[r.beat_index] = r.data_word;
      if (!r.last_beat) return;
      if (r.operation == OP_INSERT) begin
        if (r.disk_number > DISK_LIMIT || r.block_number > BLOCK_LIMIT) begin
          queue_result(ST_BAD_KEY, '0, '0, 1'b1);
          return;
        end
        if (!enabled) begin
          queue_result(ST_DISABLED, '0, '0, 1'b1);
          return;
        end
        if (find_line(n, k) >= 0) begin
          queue_result(ST_PRESENT, '0, '0, 1'b1);
          return;
        end
        victim = -1;
        for (int i = 0; i < n && victim < 0; i++)
          if (!line_valid[i]) victim = i;
        if (victim < 0) begin
          best = '0;
          for (int i = 0; i < n; i++) begin
            age = tick - line_stamp[i];
            if (i == 0 || age > best) begin
              best = age;
              victim = i;
            end
          end
        end
        line_valid[victim] = 1'b1;
        line_key[victim] = k;
        fill_line(victim);
        queue_result(ST_OK, '0, '0, 1'b1);
      end else begin
        if (!enabled) begin
          queue_result(ST_DISABLED, '0, '0, 1'b1);
          return;
        end
        any = 1'b0;
        for (int i = 0; i < n; i++)
          if (line_valid[i] && line_key[i] == k) begin
            fill_line(i);
            any = 1'b1;
          end
        queue_result(any ? ST_OK : ST_MISS, '0, '0, 1'b1);
      end
    end
  endtask

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t: mismatch in %s: expected %h, actual %h", $time, field, exp_v, act_v);
    errors++;
  endtask

  task automatic check_result(out_req_t got);
    out_req_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) report("status", want.status, got.status);
    if (got.read_word !== want.read_word) report("read_word", want.read_word, got.read_word);
    if (got.read_beat !== want.read_beat) report("read_beat", want.read_beat, got.read_beat);
    if (got.last_result !== want.last_result)
      report("last_result", want.last_result, got.last_result);
    if (got.query_total !== want.query_total)
      report("query_total", want.query_total, got.query_total);
    if (got.hit_total !== want.hit_total) report("hit_total", want.hit_total, got.hit_total);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      enabled = 1'b0;
      use_count = 2;
      tick = '0;
      query_count = '0;
      hit_count = '0;
      for (int i = 0; i < NENT; i++) line_valid[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_req);
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLE) begin
          enabled = cfg_data[0];
          if (!enabled) for (int i = 0; i < NENT; i++) line_valid[i] = 1'b0;
        end else if (cfg_index == CFG_ENTRIES) begin
          use_count = int'(cfg_data);
        end
      end
      if (in_valid && in_ready) predict_request(in_req);
    end
  end

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of the LRU block cache
// Drives directed and random request streams through several register
// settings with random gaps on both channels and reports the verdict from
// the scoreboard's failure and pending counts.
// ---------------------------------------------------------------------------
module tb_top;
  import lbc_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE      = 600;
  localparam int TOTAL_ITEMS = 450;

  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_req_t               in_req;
  logic                  out_valid;
  logic                  out_ready;
  out_req_t              out_req;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    items_sent;
  int                    idle_cycles;
  bit                    long_hold_req;

  lru_block_cache uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_req(out_req),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lbc_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_req(out_req),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic [1:0] op, logic [4:0] disk, logic [8:0] blk,
                      logic [63:0] data, logic [4:0] beat, logic last);
    int gap;
    in_valid <= 1'b1;
    in_req   <= '{op, disk, blk, data, beat, last};
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic random_key(output logic [4:0] disk, output logic [8:0] blk);
    if ($urandom_range(0, 99) < 80) begin
      disk = 5'($urandom_range(0, 1));
      blk  = 9'($urandom_range(0, 5));
    end else begin
      disk = 5'($urandom);
      blk  = 9'($urandom);
    end
  endtask

  task automatic random_request();
    logic [4:0] disk;
    logic [8:0] blk;
    logic [1:0] op;
    int         r;
    int         beats;
    random_key(disk, blk);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send(OP_LOOKUP, disk, blk, rand_word(), 5'($urandom), 1'($urandom));
    end else if (r < 85) begin
      op = (r < 65) ? OP_INSERT : OP_UPDATE;
      beats = $urandom_range(1, 3);
      for (int i = 0; i < beats; i++)
        send(op, disk, blk, rand_word(), 5'($urandom), i == beats - 1);
    end else if (r < 90) begin
      send(OP_IGNORED, disk, blk, rand_word(), 5'($urandom), 1'($urandom));
    end else begin
      op = $urandom_range(0, 1) ? OP_INSERT : OP_UPDATE;
      send(op, disk, blk, rand_word(), 5'($urandom), 1'b0);
    end
  endtask

  initial begin
    int burst;
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
        out_ready <= 1'b1;
        repeat (burst) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int use_table [8] = '{2, 256, 3, 8, 4, 2, 16, 5};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    items_sent = 0;
    idle_cycles = 0;
    long_hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_LOOKUP, 5'd0, 9'd0, '0, '0, 1'b0);
    send(OP_IGNORED, 5'd31, 9'd511, '1, 5'd31, 1'b1);
    for (int i = 0; i < 32; i++)
      send(OP_UPDATE, 5'd0, 9'd0, (i == 0) ? '0 : (i == 1) ? '1 : rand_word(), 5'(i),
           i == 31);
    send(OP_INSERT, 5'd17, 9'd0, rand_word(), 5'd0, 1'b1);
    send(OP_INSERT, 5'd0, 9'd257, rand_word(), 5'd1, 1'b1);
    send(OP_INSERT, 5'd16, 9'd256, rand_word(), 5'd2, 1'b1);
    drain();

    write_reg(CFG_ENABLE, 9'd1);
    write_reg(CFG_ENTRIES, 9'd2);
    send(OP_INSERT, 5'd16, 9'd256, '1, 5'd31, 1'b1);
    send(OP_INSERT, 5'd16, 9'd256, rand_word(), 5'd3, 1'b1);
    send(OP_LOOKUP, 5'd16, 9'd256, '0, '0, 1'b0);
    send(OP_LOOKUP, 5'd0, 9'd0, '0, '0, 1'b0);
    send(OP_UPDATE, 5'd0, 9'd0, rand_word(), 5'd4, 1'b1);
    send(OP_UPDATE, 5'd16, 9'd256, '0, 5'd0, 1'b1);
    send(OP_INSERT, 5'd0, 9'd1, rand_word(), 5'd5, 1'b1);
    send(OP_INSERT, 5'd0, 9'd2, rand_word(), 5'd6, 1'b1);
    send(OP_LOOKUP, 5'd31, 9'd511, '1, 5'd31, 1'b1);
    send(OP_LOOKUP, 5'd0, 9'd2, '0, '0, 1'b0);
    send(OP_IGNORED, 5'd0, 9'd0, '0, '0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      drain();
      if (p == 4) write_reg(CFG_ENABLE, 9'd0);
      if (p == 5) write_reg(CFG_ENABLE, 9'd1);
      write_reg(CFG_ENTRIES, CFG_DATA_W'(use_table[p]));
      if (p == 0) long_hold_req = 1'b1;
      while (items_sent < 60 + (p + 1) * (TOTAL_ITEMS - 60) / 8) random_request();
    end
    drain();

    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
